/* rtl/core/pdfe_pkg.sv */
// shared types and constants for the pwm duty fade engine
package pdfe_pkg;

   // field widths
   localparam int DUTY_W = 10;
   localparam int TICK_W = 16;

   // full-scale duty after reset
   localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 10'd1000;

   // request command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_MOVE = 1'b1;

   // request payload
   typedef struct packed {
      logic              cmd;
      logic [DUTY_W-1:0] target_duty;
      logic [TICK_W-1:0] fade_ticks;
   } req_type;

   // response payload
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              fading;
      logic              fade_done;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic run_move;
      logic run_tick;
      logic apply_plan;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_move;
      logic change_zero;
      logic div_last;
   } dp_status_type;

endpackage

/* rtl/core/pwm_duty_fade_engine.sv */
// pwm duty fade engine top level
//
// Request channel (req_valid, req_stall, req_data): a tick request advances
// the running fade by one tick; a move request clamps the duty and target to
// max_duty and plans a linear fade over fade_ticks ticks (zero counts as one).
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response per
// request with the duty after it, whether a fade runs, and a done flag on the
// tick that applied the closing step.
// Register port (csr_valid, csr_ready, csr_data): writes max_duty; always ready.
// Sequencing: a tick, or a move that changes nothing, is answered from the
// execute state once the output register is free; a move that starts a fade
// first waits for the serial divider that plans the step size or pace.
// One request is worked at a time; the next request is taken the cycle after
// the response is loaded.
// A stalled response holds in the output register while the next request is
// taken; that request then waits until the output register frees.
// Reset clears the duty and fade state and sets max_duty to 1000.
module pwm_duty_fade_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pdfe_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pdfe_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pdfe_pkg::DUTY_W-1:0]  csr_data
);

   pdfe_pkg::ctrl_cmd_type  cmd;
   pdfe_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   pdfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdfe_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/core/pdfe_div.sv */
// serial restoring divider, one quotient bit per cycle
module pdfe_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pdfe_pkg::TICK_W-1:0]  dividend,
   input  logic [pdfe_pkg::TICK_W-1:0]  divisor,
   output logic [pdfe_pkg::TICK_W-1:0]  quotient,
   output logic [pdfe_pkg::TICK_W-1:0]  remainder,
   output logic                         last
);

   localparam int W     = pdfe_pkg::TICK_W;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   logic             running_ff, running_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [W:0]       rem_shift;
   logic [W:0]       rem_trial;

   // one shift and trial subtract per cycle
   always_comb begin
      rem_shift  = {rem_ff, quo_ff[W-1]};
      rem_trial  = rem_shift - {1'b0, dsr_ff};
      running_in = running_ff;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;
      if (start) begin
         running_in = 1'b1;
         count_in   = '0;
         quo_in     = dividend;
         rem_in     = '0;
         dsr_in     = divisor;
      end else if (running_ff) begin
         if (rem_shift >= {1'b0, dsr_ff}) begin
            rem_in = rem_trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_LAST) begin
            running_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         count_ff   <= count_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign last      = running_ff && (count_ff == CNT_LAST);

endmodule

/* rtl/core/pdfe_dp.sv */
// fade datapath: fade state, move planning, tick stepping and response register
module pdfe_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [pdfe_pkg::DUTY_W-1:0]  csr_data,
   input  pdfe_pkg::req_type            req_data,
   input  pdfe_pkg::ctrl_cmd_type       cmd,
   output pdfe_pkg::dp_status_type      status,
   output pdfe_pkg::rsp_type            rsp_data
);

   localparam int DW = pdfe_pkg::DUTY_W;
   localparam int TW = pdfe_pkg::TICK_W;

   // held request
   pdfe_pkg::req_type req_ff;
   pdfe_pkg::rsp_type rsp_ff, rsp_in;

   logic [DW-1:0] max_duty_ff;

   // fade state
   logic [DW-1:0] duty_now_ff, duty_now_in;
   logic          fade_active_ff, fade_active_in;
   logic          going_up_ff, going_up_in;
   logic [DW-1:0] step_size_ff, step_size_in;
   logic [DW-1:0] step_p2_ff, step_p2_in;
   logic [DW-1:0] final_step_ff, final_step_in;
   logic [TW-1:0] ticks_left_ff, ticks_left_in;
   logic [TW-1:0] ticks_p2_ff, ticks_p2_in;
   logic [TW-1:0] pace_count_ff, pace_count_in;
   logic [TW-1:0] pace_reload_ff, pace_reload_in;
   logic [DW-1:0] steps_left_ff, steps_left_in;

   // move plan operands
   logic [DW-1:0] change_ff, change_in;
   logic [TW-1:0] fade_ff, fade_in;
   logic          fast_ff, fast_in;

   logic [DW-1:0] cur_clamp, tgt_clamp, change_w;
   logic [TW-1:0] fade_w, dividend, divisor, quotient, remainder;
   logic          up_w, fast_w, div_start, div_last;
   logic [DW-1:0] step_pick, duty_stepped;

   // clamp and measure the requested move
   always_comb begin
      cur_clamp = (duty_now_ff > max_duty_ff) ? max_duty_ff : duty_now_ff;
      tgt_clamp = (req_ff.target_duty > max_duty_ff) ? max_duty_ff : req_ff.target_duty;
      up_w      = tgt_clamp >= cur_clamp;
      change_w  = up_w ? (tgt_clamp - cur_clamp) : (cur_clamp - tgt_clamp);
      fade_w    = (req_ff.fade_ticks == '0) ? TW'(1) : req_ff.fade_ticks;
      fast_w    = {{(TW-DW){1'b0}}, change_w} >= fade_w;
      dividend  = fast_w ? {{(TW-DW){1'b0}}, change_w} : fade_w;
      divisor   = fast_w ? fade_w : {{(TW-DW){1'b0}}, change_w};
   end

   pdfe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .last      (div_last)
   );

   // step applied by a tick: the closing step once the tick count is spent
   always_comb begin
      step_pick    = (ticks_left_ff != '0) ? step_size_ff : final_step_ff;
      duty_stepped = going_up_ff ? (duty_now_ff + step_pick) : (duty_now_ff - step_pick);
   end

   // next state per command
   always_comb begin
      duty_now_in    = duty_now_ff;
      fade_active_in = fade_active_ff;
      going_up_in    = going_up_ff;
      step_size_in   = step_size_ff;
      step_p2_in     = step_p2_ff;
      final_step_in  = final_step_ff;
      ticks_left_in  = ticks_left_ff;
      ticks_p2_in    = ticks_p2_ff;
      pace_count_in  = pace_count_ff;
      pace_reload_in = pace_reload_ff;
      steps_left_in  = steps_left_ff;
      change_in      = change_ff;
      fade_in        = fade_ff;
      fast_in        = fast_ff;
      rsp_in         = rsp_ff;
      div_start      = 1'b0;
      priority if (cmd.run_move) begin
         // drop any fade and set up a new one from the clamped duty
         duty_now_in    = cur_clamp;
         going_up_in    = up_w;
         change_in      = change_w;
         fade_in        = fade_w;
         fast_in        = fast_w;
         fade_active_in = 1'b0;
         step_size_in   = '0;
         step_p2_in     = '0;
         final_step_in  = '0;
         ticks_left_in  = '0;
         ticks_p2_in    = '0;
         pace_count_in  = '0;
         pace_reload_in = '0;
         steps_left_in  = '0;
         if (change_w == '0) begin
            rsp_in = '{duty: cur_clamp, fading: 1'b0, fade_done: 1'b0};
         end else begin
            div_start = 1'b1;
         end
      end else if (cmd.apply_plan) begin
         fade_active_in = 1'b1;
         if (fast_ff) begin
            step_p2_in    = quotient[DW-1:0];
            final_step_in = quotient[DW-1:0];
            if (remainder == '0) begin
               step_size_in  = quotient[DW-1:0];
               ticks_left_in = fade_ff - 1'b1;
               ticks_p2_in   = '0;
            end else begin
               step_size_in  = quotient[DW-1:0] + 1'b1;
               ticks_left_in = remainder;
               ticks_p2_in   = fade_ff - remainder;
            end
         end else begin
            // slow fade: unit steps paced by fade/change ticks
            step_size_in   = DW'(1);
            pace_reload_in = quotient;
            pace_count_in  = quotient;
            steps_left_in  = change_ff;
            ticks_left_in  = fade_ff - remainder;
         end
         rsp_in = '{duty: duty_now_ff, fading: 1'b1, fade_done: 1'b0};
      end else if (cmd.run_tick) begin
         rsp_in = '{duty: duty_now_ff, fading: fade_active_ff, fade_done: 1'b0};
         if (fade_active_ff) begin
            if (ticks_left_ff != '0) begin
               ticks_left_in = ticks_left_ff - 1'b1;
               if (pace_count_ff > TW'(1)) begin
                  pace_count_in = pace_count_ff - 1'b1;
               end else begin
                  if (steps_left_ff != '0) begin
                     steps_left_in = steps_left_ff - 1'b1;
                     pace_count_in = pace_reload_ff;
                  end
                  duty_now_in = duty_stepped;
                  rsp_in.duty = duty_stepped;
                  // switch to the quotient step after the remainder ticks
                  if ((ticks_left_ff == TW'(1)) && (ticks_p2_ff != '0)) begin
                     ticks_left_in = ticks_p2_ff - 1'b1;
                     step_size_in  = step_p2_ff;
                     ticks_p2_in   = '0;
                  end
               end
            end else begin
               // closing tick
               pace_count_in  = '0;
               pace_reload_in = '0;
               steps_left_in  = '0;
               duty_now_in    = duty_stepped;
               fade_active_in = 1'b0;
               rsp_in         = '{duty: duty_stepped, fading: 1'b0, fade_done: 1'b1};
            end
         end
      end else begin
         // no command: everything holds
         div_start = 1'b0;
      end
   end

   // fade state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff    <= pdfe_pkg::MAX_DUTY_RESET;
         duty_now_ff    <= '0;
         fade_active_ff <= 1'b0;
         going_up_ff    <= 1'b0;
         step_size_ff   <= '0;
         step_p2_ff     <= '0;
         final_step_ff  <= '0;
         ticks_left_ff  <= '0;
         ticks_p2_ff    <= '0;
         pace_count_ff  <= '0;
         pace_reload_ff <= '0;
         steps_left_ff  <= '0;
      end else begin
         if (csr_we) begin
            max_duty_ff <= csr_data;
         end
         duty_now_ff    <= duty_now_in;
         fade_active_ff <= fade_active_in;
         going_up_ff    <= going_up_in;
         step_size_ff   <= step_size_in;
         step_p2_ff     <= step_p2_in;
         final_step_ff  <= final_step_in;
         ticks_left_ff  <= ticks_left_in;
         ticks_p2_ff    <= ticks_p2_in;
         pace_count_ff  <= pace_count_in;
         pace_reload_ff <= pace_reload_in;
         steps_left_ff  <= steps_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      change_ff <= change_in;
      fade_ff   <= fade_in;
      fast_ff   <= fast_in;
      rsp_ff    <= rsp_in;
   end

   assign status.is_move     = req_ff.cmd == pdfe_pkg::CMD_MOVE;
   assign status.change_zero = change_w == '0;
   assign status.div_last    = div_last;
   assign rsp_data           = rsp_ff;

endmodule

/* rtl/core/pdfe_ctrl.sv */
// controller: request sequencing, divide wait and response handshake
module pdfe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  pdfe_pkg::dp_status_type  status,
   output pdfe_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, out_load;

   // output register can take a new response
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_move && !status.change_zero) begin
               cmd.run_move = 1'b1;
               state_in     = ST_DIV;
            end else if (out_free) begin
               cmd.run_move = status.is_move;
               cmd.run_tick = !status.is_move;
               out_load     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.apply_plan = 1'b1;
               out_load       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/pdfe_checker.sv */
// port-level checks for the pwm duty fade engine
module pdfe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input pdfe_pkg::rsp_type            rsp_data
);

   // response held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a finished fade is never reported as still fading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fading && rsp_data.fade_done))
      else $error("fade_done with fading set");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pwm_duty_fade_engine pdfe_checker u_pdfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* test/pwm_duty_fade_engine_tb.sv */
// testbench for the pwm duty fade engine: directed fades, duty ceiling extremes, random traffic
module pwm_duty_fade_engine_tb;

   localparam int DW            = pdfe_pkg::DUTY_W;
   localparam int TW            = pdfe_pkg::TICK_W;
   localparam int REQ_W         = $bits(pdfe_pkg::req_type);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pdfe_pkg::req_type   req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   pdfe_pkg::rsp_type   rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [DW-1:0]       csr_data  = '0;

   // idle and stall odds in percent per cycle
   int idle_pct  = 0;
   int stall_pct = 0;

   // run bookkeeping
   int cycle_cnt = 0;
   int err_cnt   = 0;
   int req_cnt   = 0;
   int move_cnt  = 0;
   int rsp_cnt   = 0;
   int done_cnt  = 0;
   int csr_cnt   = 0;

   // responses owed by the engine, oldest first
   pdfe_pkg::rsp_type duty_report_q[$];

   // mirror of the engine state and its register
   logic [DW-1:0] duty_ceiling = pdfe_pkg::MAX_DUTY_RESET;
   logic [DW-1:0] cur_duty     = '0;
   bit            in_fade      = 1'b0;
   bit            rising       = 1'b0;
   logic [DW-1:0] goal_duty    = '0;
   logic [DW-1:0] step_amt     = '0;
   logic [DW-1:0] step_tail    = '0;
   logic [DW-1:0] closing_step = '0;
   logic [TW-1:0] tick_cnt     = '0;
   logic [TW-1:0] tick_tail    = '0;
   logic [TW-1:0] pace_cnt     = '0;
   logic [TW-1:0] pace_len     = '0;
   logic [DW-1:0] unit_steps   = '0;

   pwm_duty_fade_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle count and watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout: run went past %0d cycles", CYCLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_cnt, msg);
      err_cnt++;
   endtask

   // duty after one step in the current direction, wrapping in 10 bits
   function automatic logic [DW-1:0] stepped_duty(input logic [DW-1:0] amt);
      return rising ? cur_duty + amt : cur_duty - amt;
   endfunction

   // advance the mirrored engine by one request and form its response
   task automatic fade_advance(input pdfe_pkg::req_type r, output pdfe_pkg::rsp_type o);
      logic [TW-1:0] span, q, rem;
      logic [DW-1:0] start_duty, goal, change;
      bit done;
      done = 1'b0;
      if (r.cmd == pdfe_pkg::CMD_MOVE) begin
         // clamp both ends, plan a fresh fade
         span       = (r.fade_ticks == '0) ? TW'(1) : r.fade_ticks;
         start_duty = (cur_duty > duty_ceiling) ? duty_ceiling : cur_duty;
         goal       = (r.target_duty > duty_ceiling) ? duty_ceiling : r.target_duty;
         cur_duty   = start_duty;
         goal_duty  = goal;
         rising     = (goal >= start_duty);
         change     = rising ? goal - start_duty : start_duty - goal;
         step_amt     = '0;
         step_tail    = '0;
         closing_step = '0;
         tick_cnt     = '0;
         tick_tail    = '0;
         pace_cnt     = '0;
         pace_len     = '0;
         unit_steps   = '0;
         in_fade      = (change != '0);
         if (change != '0 && TW'(change) >= span) begin
            // fast mode: quotient steps, remainder ticks one larger
            q            = TW'(change) / span;
            rem          = TW'(change) - q * span;
            step_tail    = DW'(q);
            closing_step = DW'(q);
            if (rem == '0) begin
               step_amt  = DW'(q);
               tick_cnt  = span - 1'b1;
               tick_tail = '0;
            end else begin
               step_amt  = DW'(q + 1'b1);
               tick_cnt  = rem;
               tick_tail = span - rem;
            end
         end else if (change != '0) begin
            // slow mode: unit steps paced over several ticks
            step_amt   = DW'(1);
            pace_len   = span / TW'(change);
            pace_cnt   = pace_len;
            unit_steps = change;
            tick_cnt   = TW'(change) * pace_len;
         end
      end else if (in_fade) begin
         if (tick_cnt != '0) begin
            tick_cnt = tick_cnt - 1'b1;
            if (pace_cnt > TW'(1)) begin
               pace_cnt = pace_cnt - 1'b1;
            end else begin
               if (unit_steps != '0) begin
                  unit_steps = unit_steps - 1'b1;
                  pace_cnt   = pace_len;
               end
               cur_duty = stepped_duty(step_amt);
               // switch to the quotient step once the remainder ticks are used
               if (tick_cnt == '0 && tick_tail != '0) begin
                  tick_cnt  = tick_tail - 1'b1;
                  step_amt  = step_tail;
                  tick_tail = '0;
               end
            end
         end else begin
            // closing tick
            pace_cnt   = '0;
            pace_len   = '0;
            unit_steps = '0;
            cur_duty   = stepped_duty(closing_step);
            in_fade    = 1'b0;
            done       = 1'b1;
         end
      end
      o.duty      = cur_duty;
      o.fading    = in_fade;
      o.fade_done = done;
   endtask

   // response check and random receiver stall
   always @(posedge clock) begin
      pdfe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (duty_report_q.size() == 0) begin
            flag_error($sformatf("response with no request pending, duty %0d", rsp_data.duty));
         end else begin
            want = duty_report_q.pop_front();
            rsp_cnt++;
            if (want.fade_done) done_cnt++;
            if (rsp_data.duty !== want.duty)
               flag_error($sformatf("duty got %0d want %0d", rsp_data.duty, want.duty));
            if (rsp_data.fading !== want.fading)
               flag_error($sformatf("fading got %b want %b", rsp_data.fading, want.fading));
            if (rsp_data.fade_done !== want.fade_done)
               flag_error($sformatf("fade_done got %b want %b",
                                    rsp_data.fade_done, want.fade_done));
         end
      end
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // send one request, with a random idle gap in front of it
   task automatic send_request(input pdfe_pkg::req_type r);
      pdfe_pkg::rsp_type want;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fade_advance(r, want);
      duty_report_q.push_back(want);
      req_cnt++;
      if (r.cmd == pdfe_pkg::CMD_MOVE) move_cnt++;
   endtask

   task automatic send_move(input int tgt, input int fade);
      pdfe_pkg::req_type r;
      r.cmd         = pdfe_pkg::CMD_MOVE;
      r.target_duty = tgt[DW-1:0];
      r.fade_ticks  = fade[TW-1:0];
      send_request(r);
   endtask

   // ticks carry random junk in the unused fields
   task automatic send_ticks(input int n);
      pdfe_pkg::req_type r;
      for (int i = 0; i < n; i++) begin
         r.cmd         = pdfe_pkg::CMD_TICK;
         r.target_duty = DW'($urandom);
         r.fade_ticks  = TW'($urandom);
         send_request(r);
      end
   endtask

   // stop sending, wait for every owed response, then let the engine settle
   task automatic drain_responses(input int settle);
      req_valid <= 1'b0;
      while (duty_report_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // write max_duty once the engine is quiet
   task automatic write_duty_ceiling(input logic [DW-1:0] value);
      drain_responses(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      duty_ceiling = value;
      csr_valid <= 1'b0;
      csr_cnt++;
   endtask

   // ticks with nothing running, target clamp, zero fade time, zero change
   task automatic test_idle_and_clamp();
      send_ticks(1);
      send_move(1023, 0);
      send_ticks(1);
      send_move(1000, 5);
      send_ticks(1);
   endtask

   // fast fade with remainder, fast fade with no remainder, slow paced fade
   task automatic test_fade_shapes();
      send_move(990, 3);
      send_ticks(3);
      send_move(984, 3);
      send_ticks(3);
      send_move(986, 5);
      send_ticks(5);
   endtask

   // longest fade time, dropped by a new move partway through
   task automatic test_move_interrupt();
      send_move(0, 65535);
      send_ticks(2);
      send_move(1023, 0);
      send_ticks(1);
   endtask

   // ceiling at zero, at one and at full scale
   task automatic test_duty_ceiling();
      write_duty_ceiling('0);
      send_move(500, 4);
      send_ticks(1);
      write_duty_ceiling(DW'(1));
      send_move(0, 2);
      send_ticks(3);
      write_duty_ceiling(10'd1023);
      send_move(1023, 1);
      send_ticks(1);
   endtask

   // mostly complete fades with random content, some cut short, some noise
   task automatic test_random_traffic(input int idle, input int stall,
                                      input logic [DW-1:0] ceiling, input int n_items);
      int stop_at, pick, fade, tgt, n_ticks;
      pdfe_pkg::req_type r;
      write_duty_ceiling(ceiling);
      idle_pct  = idle;
      stall_pct = stall;
      stop_at   = req_cnt + n_items;
      while (req_cnt < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            r = REQ_W'($urandom);
            send_request(r);
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)      fade = $urandom_range(16, 0);
            else if (pick < 85) fade = $urandom_range(64, 17);
            else                fade = $urandom_range(65535, 0);
            // targets near the present duty exercise the slow mode
            if ($urandom_range(99) < 50)
               tgt = int'(cur_duty) + int'($urandom_range(40, 0)) - 20;
            else
               tgt = $urandom_range(1023, 0);
            if (tgt < 0)    tgt = 0;
            if (tgt > 1023) tgt = 1023;
            send_move(tgt, fade);
            if (fade <= 64 && $urandom_range(99) < 80)
               n_ticks = ((fade == 0) ? 1 : fade) + 1 + int'($urandom_range(2, 0));
            else
               n_ticks = $urandom_range(8, 0);
            send_ticks(n_ticks);
         end
      end
      // let every owed response come home before the next phase
      drain_responses(SETTLE_CYCLES);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_clamp();
      test_fade_shapes();
      test_move_interrupt();
      test_duty_ceiling();
      test_random_traffic(0, 0, pdfe_pkg::MAX_DUTY_RESET, 220);
      test_random_traffic(64, 0, 10'd1023, 220);
      test_random_traffic(0, 64, DW'($urandom_range(1023, 1)), 220);
      test_random_traffic(30, 30, DW'($urandom_range(1023, 1)), 220);

      drain_responses(SETTLE_CYCLES);
      $display("run covered %0d requests (%0d moves) across %0d max_duty writes",
               req_cnt, move_cnt, csr_cnt);
      $display("and four idle mixes; %0d responses checked, %0d fades ran to the end, %0d errors",
               rsp_cnt, done_cnt, err_cnt);
      if (err_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
